@@ sv/column_occurrence_delivery_top_macros.svh @@
// assertion helpers for the column occurrence delivery block
`ifndef COLUMN_OCCURRENCE_DELIVERY_TOP_MACROS_SVH
`define COLUMN_OCCURRENCE_DELIVERY_TOP_MACROS_SVH

// same-cycle implication
`define COD_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define COD_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/cod_pkg.sv @@
`timescale 1ns / 1ps
package cod_pkg;

    localparam int COLUMNS    = 4096;
    localparam int COUNT_BITS = 20;
    localparam int ROW_BITS   = 20;

    localparam int COL_W      = 12;
    localparam int SLOT_W     = 20;
    localparam int ROWID_W    = 20;
    localparam int LIMIT_W    = 13;
    localparam int IDX_W      = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 56;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_DELIVER_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRACK_FIRST  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_LIMIT = 2'd2;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 13'd4096;

    localparam logic ACTION_ELEMENT = 1'b0;
    localparam logic ACTION_READ    = 1'b1;

    typedef logic [COUNT_BITS-1:0] count_t;
    typedef logic [IDX_W-1:0]      idx_t;

    localparam count_t COUNT_MAX = '1;

    // request handed from the row filter to the count update stage
    typedef struct packed {
        logic               load;
        logic               is_read;
        logic               in_range;
        logic [ROWID_W-1:0] row_id;
        logic [COL_W-1:0]   column;
    } issue_t;

    function automatic idx_t col_index(input logic [COL_W-1:0] col);
        return idx_t'(col);
    endfunction

endpackage

@@ sv/cod_count_ram.sv @@
`timescale 1ns / 1ps
module cod_count_ram
    import cod_pkg::*;
(
    input  logic   aclk,
    input  logic   we,
    input  idx_t   waddr,
    input  count_t wdata,
    input  logic   re,
    input  idx_t   raddr,
    output count_t rdata
);

    count_t mem [COLUMNS];
    count_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/cod_row_filter.sv @@
`timescale 1ns / 1ps
module cod_row_filter
    import cod_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               accept,
    input  logic               action,
    input  logic [ROWID_W-1:0] row_id,
    input  logic [COL_W-1:0]   column,
    input  logic               row_end,
    input  logic [LIMIT_W-1:0] column_limit,
    output issue_t             issue
);

    logic row_stopped_reg;
    logic row_stopped_next;
    logic over_limit;
    logic in_range;

    assign in_range   = 32'(column) < 32'(COLUMNS);
    assign over_limit = (32'(column) >= 32'(column_limit)) || !in_range;

    always_comb begin
        row_stopped_next = row_stopped_reg;
        if (accept && action == ACTION_ELEMENT) begin
            if (row_stopped_reg || over_limit) begin
                row_stopped_next = !row_end;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_stopped_reg <= 1'b0;
        end else begin
            row_stopped_reg <= row_stopped_next;
        end
    end

    always_comb begin
        issue.load     = accept && (action == ACTION_READ ||
                                    (!row_stopped_reg && !over_limit));
        issue.is_read  = action == ACTION_READ;
        issue.in_range = in_range;
        issue.row_id   = row_id;
        issue.column   = column;
    end

endmodule

@@ sv/cod_count_update.sv @@
`timescale 1ns / 1ps
module cod_count_update
    import cod_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  issue_t               issue,
    input  logic                 deliver_mode,
    input  logic                 track_first,
    output logic                 in_ready,
    output logic                 clear_busy,
    output logic                 ram_we,
    output idx_t                 ram_waddr,
    output count_t               ram_wdata,
    output logic                 ram_re,
    output idx_t                 ram_raddr,
    input  count_t               ram_rdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata
);

    logic                 clear_busy_reg;
    idx_t                 clear_idx_reg;
    logic                 p1_valid_reg;
    logic                 p1_valid_next;
    issue_t               p1_reg;
    logic                 fwd_valid_reg;
    idx_t                 fwd_addr_reg;
    count_t               fwd_data_reg;
    logic                 m_valid_reg;
    logic [M_TDATA_W-1:0] m_data_reg;

    idx_t                 p1_idx;
    logic                 advance;
    count_t               old_count;
    count_t               new_count;
    logic                 sat;
    logic                 first;
    logic [SLOT_W-1:0]    slot;
    logic [ROWID_W-1:0]   out_row;
    logic [M_TDATA_W-1:0] packed_result;

    assign p1_idx  = col_index(p1_reg.column);
    assign advance = p1_valid_reg && (!m_valid_reg || m_tready);

    // the write of the previous edge is not yet visible in the read data
    assign old_count = (fwd_valid_reg && fwd_addr_reg == p1_idx) ? fwd_data_reg : ram_rdata;

    always_comb begin
        sat   = 1'b0;
        first = 1'b0;
        if (p1_reg.is_read) begin
            new_count = '0;
        end else begin
            sat       = old_count == COUNT_MAX;
            first     = track_first && old_count == '0;
            new_count = sat ? old_count : old_count + count_t'(1);
        end
    end

    assign slot    = p1_reg.in_range ? SLOT_W'(old_count) : '0;
    assign out_row = (!p1_reg.is_read && deliver_mode) ?
                     ROWID_W'(ROW_BITS'(p1_reg.row_id)) : '0;
    assign packed_result = {2'b00, sat, first, out_row, slot, p1_reg.column};

    assign ram_re    = issue.load && issue.in_range;
    assign ram_raddr = col_index(issue.column);
    assign ram_we    = clear_busy_reg || (advance && p1_reg.in_range);
    assign ram_waddr = clear_busy_reg ? clear_idx_reg : p1_idx;
    assign ram_wdata = clear_busy_reg ? '0 : new_count;

    assign in_ready   = !clear_busy_reg && (!p1_valid_reg || advance);
    assign clear_busy = clear_busy_reg;

    always_comb begin
        p1_valid_next = p1_valid_reg;
        if (issue.load) begin
            p1_valid_next = 1'b1;
        end else if (advance) begin
            p1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clear_busy_reg <= 1'b1;
            clear_idx_reg  <= '0;
            p1_valid_reg   <= 1'b0;
            fwd_valid_reg  <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (clear_busy_reg) begin
                clear_idx_reg <= clear_idx_reg + idx_t'(1);
                if (clear_idx_reg == idx_t'(COLUMNS - 1)) begin
                    clear_busy_reg <= 1'b0;
                end
            end
            p1_valid_reg <= p1_valid_next;
            if (clear_busy_reg) begin
                fwd_valid_reg <= 1'b0;
            end else if (advance && p1_reg.in_range) begin
                fwd_valid_reg <= 1'b1;
            end
            if (advance) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (issue.load) begin
            p1_reg <= issue;
        end
        if (advance && p1_reg.in_range) begin
            fwd_addr_reg <= p1_idx;
            fwd_data_reg <= new_count;
        end
        if (advance) begin
            m_data_reg <= packed_result;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

@@ sv/column_occurrence_delivery_top.sv @@
`timescale 1ns / 1ps
// column occurrence counter for sparse-matrix transpose
// s_ channel: one request per element; s_tdata = row_id [19:0], column [31:20],
// s_tuser = action (0 row element, 1 read and clear a column count),
// s_tlast = end of the current row
// m_ channel: one result per counted element or read; stopped elements and
// elements at or above the column limit give none
// cfg_ port: write deliver_mode (0), track_first (1), column_limit (2) while idle
// throughput: one request per cycle while s_tready is high; the count memory is read
// at accept and written as the request leaves the update stage, with the last write
// forwarded to the next element; a request moves from the update stage to the output register
// reset: after aresetn a clearing pass writes zero to all 4096 counts, one per
// cycle; s_tready stays low until the pass ends, config writes are taken
// stall: the output register holds a result while m_tready is low; the stage
// behind it holds one more request, then s_tready drops
module column_occurrence_delivery_top
    import cod_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,  // row_id, column
    input  logic                  s_tuser,  // action
    input  logic                  s_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,  // out_column, slot, out_row, first_touch,
                                            // saturated, zero fill
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_wr_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data
);

    `include "column_occurrence_delivery_top_macros.svh"

    logic               deliver_mode_reg;
    logic               track_first_reg;
    logic [LIMIT_W-1:0] column_limit_reg;

    logic   accept;
    issue_t issue;
    logic   in_ready;
    logic   clear_busy;
    logic   ram_we;
    idx_t   ram_waddr;
    count_t ram_wdata;
    logic   ram_re;
    idx_t   ram_raddr;
    count_t ram_rdata;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            deliver_mode_reg <= 1'b0;
            track_first_reg  <= 1'b1;
            column_limit_reg <= LIMIT_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                CFG_DELIVER_MODE: deliver_mode_reg <= cfg_wr_data[0];
                CFG_TRACK_FIRST:  track_first_reg  <= cfg_wr_data[0];
                CFG_COLUMN_LIMIT: column_limit_reg <= cfg_wr_data[LIMIT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign s_tready = in_ready;
    assign accept   = s_tvalid && in_ready;

    cod_row_filter u_row_filter (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .accept       (accept),
        .action       (s_tuser),
        .row_id       (s_tdata[ROWID_W-1:0]),
        .column       (s_tdata[ROWID_W+COL_W-1:ROWID_W]),
        .row_end      (s_tlast),
        .column_limit (column_limit_reg),
        .issue        (issue)
    );

    cod_count_update u_count_update (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .issue        (issue),
        .deliver_mode (deliver_mode_reg),
        .track_first  (track_first_reg),
        .in_ready     (in_ready),
        .clear_busy   (clear_busy),
        .ram_we       (ram_we),
        .ram_waddr    (ram_waddr),
        .ram_wdata    (ram_wdata),
        .ram_re       (ram_re),
        .ram_raddr    (ram_raddr),
        .ram_rdata    (ram_rdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata)
    );

    cod_count_ram u_count_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    `COD_ASSERT_NOW(a_no_accept_in_clear, aclk, aresetn, clear_busy, !s_tready, "request taken during clear")
    `COD_ASSERT_NEXT(a_no_result_in_clear, aclk, aresetn, clear_busy, !m_tvalid, "result during clear")
    `COD_ASSERT_NOW(a_first_means_zero, aclk, aresetn, m_tvalid && m_tdata[52], m_tdata[31:12] == '0, "first touch with nonzero slot")
    `COD_ASSERT_NOW(a_sat_not_first, aclk, aresetn, m_tvalid && m_tdata[53], !m_tdata[52], "saturated and first touch together")

endmodule

@@ bench/tb_column_occurrence_delivery_top.sv @@
`timescale 1ns / 1ps
module tb_column_occurrence_delivery_top;
    import cod_pkg::*;

    localparam int LIMIT_CYCLES = 200_000;
    localparam int HOLD_CYCLES  = 400;

    // out_column lowest, saturated highest
    typedef struct packed {
        logic               saturated;
        logic               first_touch;
        logic [ROWID_W-1:0] out_row;
        logic [SLOT_W-1:0]  slot;
        logic [COL_W-1:0]   out_column;
    } occurrence_t;

    class occurrence_board;
        count_t             column_counts [COLUMNS];
        logic               row_stopped;
        logic               deliver_mode;
        logic               track_first;
        logic [LIMIT_W-1:0] column_limit;
        occurrence_t        pending_results [$];
        int                 mismatches;

        function new();
            foreach (column_counts[i]) column_counts[i] = '0;
            row_stopped  = 1'b0;
            deliver_mode = 1'b0;
            track_first  = 1'b1;
            column_limit = LIMIT_RESET;
            mismatches   = 0;
        endfunction

        function void append_expected(occurrence_t res);
            pending_results.insert(pending_results.size(), res);
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_DELIVER_MODE: deliver_mode = value[0];
                CFG_TRACK_FIRST:  track_first  = value[0];
                CFG_COLUMN_LIMIT: column_limit = value[LIMIT_W-1:0];
                default: ;
            endcase
        endfunction

        function void count_request(logic action, logic [ROWID_W-1:0] row_id,
                                    logic [COL_W-1:0] column, logic row_end);
            occurrence_t res;
            count_t      prior;
            int          eff_limit;
            res = '0;
            if (action == ACTION_READ) begin
                res.out_column = column;
                res.slot = column_counts[column];
                column_counts[column] = '0;
                append_expected(res);
                return;
            end
            if (row_stopped) begin
                if (row_end) row_stopped = 1'b0;
                return;
            end
            eff_limit = (int'(column_limit) < COLUMNS) ? int'(column_limit) : COLUMNS;
            if (int'(column) >= eff_limit) begin
                row_stopped = !row_end;
                return;
            end
            prior = column_counts[column];
            res.out_column  = column;
            res.slot        = prior;
            res.out_row     = deliver_mode ? row_id : '0;
            res.first_touch = track_first && (prior == '0);
            res.saturated   = (prior == COUNT_MAX);
            if (!res.saturated) column_counts[column] = prior + 1'b1;
            if (row_end) row_stopped = 1'b0;
            append_expected(res);
        endfunction

        function void compare_field(string name, logic [31:0] expected, logic [31:0] actual);
            if (expected !== actual) begin
                mismatches++;
                $error("%s: expected %0d, actual %0d", name, expected, actual);
            end
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] data);
            occurrence_t got;
            occurrence_t want;
            got = data[$bits(occurrence_t)-1:0];
            if (pending_results.size() == 0) begin
                mismatches++;
                $error("unexpected result: out_column %0d slot %0d",
                       got.out_column, got.slot);
                return;
            end
            want = pending_results.pop_front();
            compare_field("out_column", want.out_column, got.out_column);
            compare_field("slot", want.slot, got.slot);
            compare_field("out_row", want.out_row, got.out_row);
            compare_field("first_touch", want.first_touch, got.first_touch);
            compare_field("saturated", want.saturated, got.saturated);
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;  // row_id, column
    logic                  s_tuser = 1'b0;  // action
    logic                  s_tlast = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;  // out_column, slot, out_row, first_touch, saturated
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_wr_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;

    occurrence_board board = new();
    bit sender_idle_en   = 1'b1;
    bit receiver_idle_en = 1'b1;
    bit hold_request     = 1'b0;
    int cycle_count      = 0;

    column_occurrence_delivery_top DUT (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .s_tlast(s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_index(cfg_wr_index),
        .cfg_wr_data(cfg_wr_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("status: fail");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) board.check_result(m_tdata);
    end

    initial begin : receiver
        @(posedge aclk);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else if (receiver_idle_en && $urandom_range(0, 2) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge aclk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
    end

    task automatic send_request(logic action, logic [ROWID_W-1:0] row_id,
                                logic [COL_W-1:0] column, logic row_end);
        if (sender_idle_en && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {column, row_id};
        s_tuser  <= action;
        s_tlast  <= row_end;
        do @(posedge aclk); while (!s_tready);
        board.count_request(action, row_id, column, row_end);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (board.pending_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= value;
        @(posedge aclk);
        board.set_register(idx, value);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic configure(logic deliver, logic track, int limit);
        drain();
        write_reg(CFG_DELIVER_MODE, CFG_DATA_W'(deliver));
        write_reg(CFG_TRACK_FIRST, CFG_DATA_W'(track));
        write_reg(CFG_COLUMN_LIMIT, CFG_DATA_W'(limit));
    endtask

    function automatic logic [COL_W-1:0] pick_column(int eff_limit);
        if (eff_limit == 0) return COL_W'($urandom_range(0, COLUMNS - 1));
        if ($urandom_range(0, 9) < 4) return COL_W'($urandom_range(0, (eff_limit > 16) ? 15 : eff_limit - 1));
        return COL_W'($urandom_range(0, eff_limit - 1));
    endfunction

    task automatic run_random(int item_total);
        int                 sent;
        int                 row_len;
        int                 eff_limit;
        logic [ROWID_W-1:0] row_id;
        logic [COL_W-1:0]   column;
        logic               row_end;
        sent = 0;
        eff_limit = (int'(board.column_limit) < COLUMNS) ? int'(board.column_limit) : COLUMNS;
        while (sent < item_total) begin
            if ($urandom_range(0, 9) == 0) begin
                send_request(ACTION_READ, ROWID_W'($urandom), pick_column(eff_limit),
                             1'($urandom));
                sent++;
            end else begin
                row_len = $urandom_range(1, 8);
                row_id  = ROWID_W'($urandom);
                for (int k = 0; k < row_len; k++) begin
                    column  = pick_column(eff_limit);
                    row_end = (k == row_len - 1) && ($urandom_range(0, 14) != 0);
                    // break the row with an out-of-range column now and then
                    if (eff_limit < COLUMNS && $urandom_range(0, 11) == 0)
                        column = COL_W'($urandom_range(eff_limit, COLUMNS - 1));
                    send_request(ACTION_ELEMENT, row_id, column, row_end);
                    sent++;
                end
            end
        end
    endtask

    initial begin : stimulus
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset defaults: count only, first tracking on, full limit
        send_request(ACTION_ELEMENT, 20'h00000, 12'h000, 1'b0);
        send_request(ACTION_ELEMENT, 20'hFFFFF, 12'hFFF, 1'b1);
        send_request(ACTION_ELEMENT, 20'h12345, 12'h000, 1'b1);
        send_request(ACTION_READ, 20'h00000, 12'h000, 1'b0);
        send_request(ACTION_READ, 20'hFFFFF, 12'h000, 1'b1);
        send_request(ACTION_READ, 20'h00000, 12'h005, 1'b0);
        send_request(ACTION_ELEMENT, 20'h54321, 12'h000, 1'b1);

        // deliver mode with a small limit: stopped rows and reads inside them
        configure(1'b1, 1'b1, 100);
        send_request(ACTION_ELEMENT, 20'hABCDE, 12'd99, 1'b0);
        send_request(ACTION_ELEMENT, 20'hABCDE, 12'd100, 1'b0);
        send_request(ACTION_ELEMENT, 20'hABCDE, 12'd3, 1'b0);
        send_request(ACTION_READ, 20'h00000, 12'd99, 1'b0);
        send_request(ACTION_ELEMENT, 20'hABCDE, 12'd4, 1'b1);
        send_request(ACTION_ELEMENT, 20'h00001, 12'd4, 1'b0);
        send_request(ACTION_ELEMENT, 20'h00001, 12'd200, 1'b1);
        send_request(ACTION_ELEMENT, 20'hFFFFF, 12'd5, 1'b1);

        configure(1'b0, 1'b0, 0);
        send_request(ACTION_ELEMENT, 20'h00002, 12'd0, 1'b1);
        send_request(ACTION_ELEMENT, 20'h00003, 12'd7, 1'b0);
        send_request(ACTION_ELEMENT, 20'h00003, 12'd7, 1'b1);
        send_request(ACTION_READ, 20'h00000, 12'd4, 1'b0);

        configure(1'b1, 1'b1, 4096);
        run_random(200);
        configure(1'b0, 1'b1, $urandom_range(1, COLUMNS - 1));
        run_random(200);

        configure(1'b1, 1'b0, 4096);
        hold_request     = 1'b1;
        sender_idle_en   = 1'b0;
        run_random(60);
        sender_idle_en   = 1'b1;
        run_random(140);

        configure(1'b0, 1'b0, 0);
        run_random(60);
        configure(1'b1, 1'b1, 1);
        run_random(150);

        configure(1'b1, 1'b1, COLUMNS - 1);
        sender_idle_en   = 1'b0;
        receiver_idle_en = 1'b0;
        run_random(240);

        drain();
        repeat (8) @(posedge aclk);
        if (board.mismatches == 0 && board.pending_results.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
